// ===== rtl/core/roil_pkg.sv =====
// Shared types and constants for the recency-ordered identifier list.
`default_nettype none
package roil_pkg;

   // Default number of cells in the row
   localparam int CAPACITY_DEF = 64;

   // Width of a position or count at the largest supported capacity (256)
   localparam int CNT_W = 9;

   localparam int ID_W   = 32;
   localparam int FUNC_W = 2;
   localparam int OUT_W  = 7;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RANK   = 2'd2;

   // Which neighbour a cell takes its identifier from
   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_LEFT,
      SHIFT_RIGHT
   } shift_type;

   // Request sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESOLVE,
      ST_APPLY
   } state_type;

   // Update command broadcast to every cell of the row
   typedef struct packed {
      logic             en;
      shift_type        mode;
      logic [CNT_W-1:0] lo;
      logic [CNT_W-1:0] hi;
      logic             load_en;
      logic [CNT_W-1:0] load_idx;
   } cell_op_type;

endpackage
`default_nettype wire

// ===== rtl/core/roil_if.sv =====
// Request and response channel interfaces of the recency-ordered identifier list.
`default_nettype none
interface roil_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] ident;
   logic        to_head;
   logic        move_existing;

   modport source (output valid, func, ident, to_head, move_existing, input ready);
   modport sink   (input valid, func, ident, to_head, move_existing, output ready);
endinterface

interface roil_rsp_if;
   logic       valid;
   logic       ready;
   logic       was_present;
   logic       newly_added;
   logic [6:0] rank;
   logic       refused_full;
   logic [6:0] length;

   modport source (output valid, was_present, newly_added, rank, refused_full, length,
                   input ready);
   modport sink   (input valid, was_present, newly_added, rank, refused_full, length,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/roil_cell.sv =====
// One cell of the list: holds one identifier, compares it and shifts with its neighbours.
`default_nettype none
module roil_cell
   import roil_pkg::*;
#(
   parameter int IDX = 0
) (
   input  wire logic            clock,
   input  wire logic            cmp_en,
   input  wire logic [ID_W-1:0] cmp_ident,
   input  wire logic [ID_W-1:0] load_ident,
   input  wire cell_op_type     op,
   input  wire logic [ID_W-1:0] left_id,
   input  wire logic [ID_W-1:0] right_id,
   output logic [ID_W-1:0]      id,
   output logic                 match
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [ID_W-1:0] id_ff;
   logic [ID_W-1:0] id_in;
   logic            match_ff;
   logic            match_in;
   logic            in_range;

   // Decide whether this cell lies in the span that shifts
   assign in_range = (MY_IDX >= op.lo) && (MY_IDX < op.hi);

   // Select the next identifier: load, take from a neighbour, or hold
   always_comb begin
      id_in = id_ff;
      if (op.en) begin
         if (op.load_en && (MY_IDX == op.load_idx)) begin
            id_in = load_ident;
         end else if (in_range) begin
            case (op.mode)
               SHIFT_LEFT:  id_in = left_id;
               SHIFT_RIGHT: id_in = right_id;
               default:     id_in = id_ff;
            endcase
         end
      end
   end

   // Capture the compare result when a request is transferred
   assign match_in = cmp_en ? (id_ff == cmp_ident) : match_ff;

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      match_ff <= match_in;
   end

   assign id    = id_ff;
   assign match = match_ff;

endmodule
`default_nettype wire

// ===== rtl/core/roil_ctrl.sv =====
// Request sequencer: resolves the match position, drives the cell row and holds the response.
`default_nettype none
module roil_ctrl
   import roil_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   roil_req_if.sink                 req_ch,
   roil_rsp_if.source               rsp_ch,
   input  wire logic [CAPACITY-1:0] match_vec,
   output logic                     cmp_en,
   output logic [ID_W-1:0]          cmp_ident,
   output logic [ID_W-1:0]          load_ident,
   output cell_op_type              op
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   state_type state_ff;
   state_type state_in;

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [FUNC_W-1:0] func_ff;
   logic [ID_W-1:0]   ident_ff;
   logic              to_head_ff;
   logic              move_ff;
   logic              found_ff;
   logic [CW-1:0]     pos_ff;

   logic              rsp_valid_ff;
   logic              present_ff;
   logic              added_ff;
   logic [OUT_W-1:0]  rank_ff;
   logic              refused_ff;
   logic [OUT_W-1:0]  length_ff;

   logic              req_xfer;
   logic              resolve_en;
   logic              apply_go;
   logic              rsp_free;

   logic [CAPACITY-1:0] match_live;
   logic [CW-1:0]       pos_or;
   logic                added_in;
   logic                refused_in;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_xfer) state_in = ST_RESOLVE;
         ST_RESOLVE: state_in = ST_APPLY;
         ST_APPLY:   if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // State outputs; refuse requests while in reset
   always_comb begin
      req_ch.ready = 1'b0;
      resolve_en   = 1'b0;
      apply_go     = 1'b0;
      case (state_ff)
         ST_IDLE:    req_ch.ready = !reset;
         ST_RESOLVE: resolve_en   = 1'b1;
         ST_APPLY:   apply_go     = rsp_free;
         default:    req_ch.ready = 1'b0;
      endcase
   end

   assign cmp_en     = req_xfer;
   assign cmp_ident  = req_ch.ident;
   assign load_ident = ident_ff;

   // Mask matches beyond the fill level and encode the single matching position
   always_comb begin
      pos_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match_live[i] = match_vec[i] && (CW'(i) < count_ff);
         if (match_live[i]) begin
            pos_or = pos_or | CW'(i);
         end
      end
   end

   // Build the row update from the resolved position
   always_comb begin
      op         = '0;
      op.mode    = SHIFT_NONE;
      op.en      = apply_go;
      count_in   = count_ff;
      added_in   = 1'b0;
      refused_in = 1'b0;
      case (func_ff)
         FUNC_ADD: begin
            if (!found_ff) begin
               if (count_ff == CAP_CNT) begin
                  refused_in = 1'b1;
               end else begin
                  added_in = 1'b1;
                  count_in = count_ff + 1'b1;
                  op.load_en = 1'b1;
                  if (to_head_ff) begin
                     op.mode     = SHIFT_LEFT;
                     op.lo       = CNT_W'(1);
                     op.hi       = CNT_W'(count_ff) + 1'b1;
                     op.load_idx = '0;
                  end else begin
                     op.load_idx = CNT_W'(count_ff);
                  end
               end
            end else if (move_ff) begin
               op.load_en = 1'b1;
               if (to_head_ff) begin
                  op.mode     = SHIFT_LEFT;
                  op.lo       = CNT_W'(1);
                  op.hi       = CNT_W'(pos_ff) + 1'b1;
                  op.load_idx = '0;
               end else begin
                  op.mode     = SHIFT_RIGHT;
                  op.lo       = CNT_W'(pos_ff);
                  op.hi       = CNT_W'(count_ff) - 1'b1;
                  op.load_idx = CNT_W'(count_ff) - 1'b1;
               end
            end
         end
         FUNC_REMOVE: begin
            if (found_ff) begin
               op.mode  = SHIFT_RIGHT;
               op.lo    = CNT_W'(pos_ff);
               op.hi    = CNT_W'(count_ff) - 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (apply_go) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request, resolve and response payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff    <= req_ch.func;
         ident_ff   <= req_ch.ident;
         to_head_ff <= req_ch.to_head;
         move_ff    <= req_ch.move_existing;
      end
      if (resolve_en) begin
         found_ff <= |match_live;
         pos_ff   <= (|match_live) ? pos_or : count_ff;
      end
      if (apply_go) begin
         present_ff <= found_ff;
         added_ff   <= added_in;
         rank_ff    <= OUT_W'(pos_ff);
         refused_ff <= refused_in;
         length_ff  <= OUT_W'(count_in);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.was_present  = present_ff;
   assign rsp_ch.newly_added  = added_ff;
   assign rsp_ch.rank         = rank_ff;
   assign rsp_ch.refused_full = refused_ff;
   assign rsp_ch.length       = length_ff;

`ifndef SYNTHESIS
   // Fill level never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("fill level above capacity");

   // Identifiers in the list are distinct, so at most one live cell matches
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |-> $onehot0(match_live))
      else $error("more than one cell matched");

   // A refused insert only happens on a full list
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && refused_ff) |-> (length_ff == OUT_W'(CAPACITY)))
      else $error("insert refused below capacity");

   // A fresh insert never reports an identifier already present
   a_added_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && added_ff) |-> (!present_ff && !refused_ff))
      else $error("insert flagged for a present identifier");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/recency_ordered_id_list.sv =====
// A request moves from transfer through resolve (compare -> position encode) to apply (row shift and
// response register); apply waits until the response register is free. A new request is taken only when
// the sequencer is back in idle, after the previous request has been applied.
// A finished response waits in its output register while the next request is taken.
// Reset (synchronous, active high) empties the list; cell contents stay undefined
// and need no clearing pass.
`default_nettype none
module recency_ordered_id_list
   import roil_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   roil_req_if.sink   req_ch,
   roil_rsp_if.source rsp_ch
);

   logic [ID_W-1:0]     cell_ids [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic                cmp_en;
   logic [ID_W-1:0]     cmp_ident;
   logic [ID_W-1:0]     load_ident;
   cell_op_type         op;

   // Sequence each request and hold its response
   roil_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .match_vec  (match_vec),
      .cmp_en     (cmp_en),
      .cmp_ident  (cmp_ident),
      .load_ident (load_ident),
      .op         (op)
   );

   // Chain the cells, head at index zero
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ID_W-1:0] left_id;
      logic [ID_W-1:0] right_id;

      if (g == 0) begin : g_head
         assign left_id = cell_ids[g];
      end else begin : g_inner_l
         assign left_id = cell_ids[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_id = cell_ids[g];
      end else begin : g_inner_r
         assign right_id = cell_ids[g+1];
      end

      roil_cell #(
         .IDX (g)
      ) u_cell (
         .clock      (clock),
         .cmp_en     (cmp_en),
         .cmp_ident  (cmp_ident),
         .load_ident (load_ident),
         .op         (op),
         .left_id    (left_id),
         .right_id   (right_id),
         .id         (cell_ids[g]),
         .match      (match_vec[g])
      );
   end

endmodule
`default_nettype wire

// ===== test/recency_ordered_id_list_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the recency-ordered identifier list.
module recency_ordered_id_list_tb;
   import roil_pkg::*;

   localparam int CAPACITY  = CAPACITY_DEF;
   localparam int POOL_SIZE = 96;
   localparam int MAX_SHOWN = 10;
   localparam int HOLD_OFF  = 200;

   // The package leaves the fourth selector unnamed; it behaves as a rank query
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   typedef struct packed {
      logic             was_present;
      logic             newly_added;
      logic [OUT_W-1:0] rank;
      logic             refused_full;
      logic [OUT_W-1:0] length;
   } list_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   roil_req_if req_bus ();
   roil_rsp_if rsp_bus ();

   recency_ordered_id_list #(
      .CAPACITY (CAPACITY)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Predicted list contents, head at index 0
   logic [ID_W-1:0] mru_ids[$];
   list_reply_type  expected_replies[$];
   logic [ID_W-1:0] id_pool[POOL_SIZE];

   int mismatch_count  = 0;
   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int rsp_hold_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Place an identifier at either end of the predicted list
   function automatic void place_id(input logic [ID_W-1:0] ident, input logic to_head);
      if (to_head)
         mru_ids.push_front(ident);
      else
         mru_ids.push_back(ident);
   endfunction

   // Apply one request to the predicted list and return the reply it must produce
   function automatic list_reply_type update_mru_list(input logic [FUNC_W-1:0] func,
                                                      input logic [ID_W-1:0] ident,
                                                      input logic to_head,
                                                      input logic move_existing);
      list_reply_type reply;
      int             pos;
      bit             found;
      reply = '0;
      pos   = mru_ids.size();
      found = 1'b0;
      for (int i = 0; i < mru_ids.size(); i++) begin
         if (mru_ids[i] == ident) begin
            pos   = i;
            found = 1'b1;
            break;
         end
      end
      case (func)
         FUNC_ADD: begin
            if (!found) begin
               if (mru_ids.size() >= CAPACITY) begin
                  reply.refused_full = 1'b1;
               end else begin
                  place_id(ident, to_head);
                  reply.newly_added = 1'b1;
               end
            end else if (move_existing) begin
               mru_ids.delete(pos);
               place_id(ident, to_head);
            end
         end
         FUNC_REMOVE: begin
            if (found)
               mru_ids.delete(pos);
         end
         default: ;
      endcase
      reply.was_present = found;
      reply.rank        = pos[OUT_W-1:0];
      reply.length      = OUT_W'(mru_ids.size());
      return reply;
   endfunction

   function automatic void note_failure(input string what, input list_reply_type want,
                                        input list_reply_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
         $display("%0t: %s: expected present %b added %b rank %0d refused %b len %0d",
                  $realtime, what, want.was_present, want.newly_added, want.rank,
                  want.refused_full, want.length);
         $display("%0t: %s: actual   present %b added %b rank %0d refused %b len %0d",
                  $realtime, what, got.was_present, got.newly_added, got.rank,
                  got.refused_full, got.length);
      end
   endfunction

   // Drive response ready: a long hold-off when asked, random stalls otherwise
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_bus.ready   = 1'b0;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Check each response transfer, then predict for each request transfer
   always @(posedge clock) begin : watch_transfers
      list_reply_type got;
      list_reply_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.was_present, rsp_bus.newly_added, rsp_bus.rank,
                    rsp_bus.refused_full, rsp_bus.length};
            if (expected_replies.size() == 0) begin
               note_failure("response with none outstanding", '0, got);
            end else begin
               want = expected_replies.pop_front();
               if (got.was_present !== want.was_present ||
                   got.newly_added !== want.newly_added ||
                   got.rank !== want.rank ||
                   got.refused_full !== want.refused_full ||
                   got.length !== want.length)
                  note_failure("response mismatch", want, got);
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_replies.push_back(update_mru_list(req_bus.func, req_bus.ident,
                                                       req_bus.to_head,
                                                       req_bus.move_existing));
      end
   end

   // Offer one request from a falling edge and hold it until the transfer
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] ident,
                               input logic to_head, input logic move_existing);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid         = 1'b1;
      req_bus.func          = func;
      req_bus.ident         = ident;
      req_bus.to_head       = to_head;
      req_bus.move_existing = move_existing;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the sender until every outstanding response has arrived
   task automatic wait_for_replies();
      req_bus.valid = 1'b0;
      while (expected_replies.size() != 0)
         @(negedge clock);
   endtask

   // Mostly identifiers in the list or in a small pool, so that hits are common
   function automatic logic [ID_W-1:0] pick_ident();
      int r;
      r = $urandom_range(99);
      if (r < 45 && mru_ids.size() != 0)
         return mru_ids[$urandom_range(mru_ids.size() - 1)];
      else if (r < 85)
         return id_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom();
   endfunction

   task automatic send_random(input int add_pct, input int remove_pct);
      int               r;
      logic [FUNC_W-1:0] func;
      r = $urandom_range(99);
      if (r < add_pct)
         func = FUNC_ADD;
      else if (r < add_pct + remove_pct)
         func = FUNC_REMOVE;
      else if (r < 95)
         func = FUNC_RANK;
      else
         func = FUNC_SPARE;
      send_request(func, pick_ident(), 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // Edge values and every request kind on a short list
   task automatic test_directed();
      send_request(FUNC_RANK,   32'h0000_0000, 1'b0, 1'b0);
      send_request(FUNC_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_request(FUNC_ADD,    32'h0000_0000, 1'b0, 1'b0);
      send_request(FUNC_ADD,    32'hFFFF_FFFF, 1'b1, 1'b1);
      send_request(FUNC_ADD,    32'hA5A5_A5A5, 1'b0, 1'b0);
      send_request(FUNC_ADD,    32'h5A5A_5A5A, 1'b1, 1'b0);
      // present without move: no change
      send_request(FUNC_ADD,    32'hFFFF_FFFF, 1'b1, 1'b0);
      send_request(FUNC_ADD,    32'h0000_0000, 1'b1, 1'b1);
      send_request(FUNC_ADD,    32'h0000_0000, 1'b0, 1'b1);
      send_request(FUNC_ADD,    32'hA5A5_A5A5, 1'b0, 1'b1);
      send_request(FUNC_RANK,   32'hFFFF_FFFF, 1'b1, 1'b1);
      // unused selector reads like a rank query
      send_request(FUNC_SPARE,  32'hA5A5_A5A5, 1'b1, 1'b1);
      send_request(FUNC_SPARE,  32'h1234_5678, 1'b0, 1'b0);
      send_request(FUNC_RANK,   32'h8000_0000, 1'b0, 1'b1);
      send_request(FUNC_REMOVE, 32'h1234_5678, 1'b0, 1'b0);
      send_request(FUNC_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_request(FUNC_REMOVE, 32'h5A5A_5A5A, 1'b1, 1'b0);
      send_request(FUNC_REMOVE, 32'h0000_0000, 1'b0, 1'b1);
      send_request(FUNC_ADD,    32'h0000_0001, 1'b1, 1'b1);
      send_request(FUNC_REMOVE, 32'hA5A5_A5A5, 1'b0, 1'b0);
      send_request(FUNC_REMOVE, 32'h0000_0001, 1'b0, 1'b0);
      send_request(FUNC_REMOVE, 32'h0000_0001, 1'b1, 1'b1);
   endtask

   // Fill to capacity, exercise refusals and moves while full, then shrink
   task automatic test_full_list();
      while (mru_ids.size() < CAPACITY)
         send_request(FUNC_ADD, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      send_request(FUNC_ADD,    $urandom(), 1'b1, 1'b0);
      send_request(FUNC_ADD,    $urandom(), 1'b0, 1'b1);
      send_request(FUNC_RANK,   $urandom(), 1'b0, 1'b0);
      send_request(FUNC_ADD,    mru_ids[CAPACITY - 1], 1'b1, 1'b1);
      send_request(FUNC_ADD,    mru_ids[0], 1'b0, 1'b1);
      send_request(FUNC_ADD,    mru_ids[10], 1'b1, 1'b0);
      send_request(FUNC_SPARE,  mru_ids[CAPACITY - 1], 1'b0, 1'b0);
      send_request(FUNC_REMOVE, mru_ids[5], 1'b0, 1'b0);
      send_request(FUNC_ADD,    $urandom(), 1'b0, 1'b0);
      send_request(FUNC_ADD,    $urandom(), 1'b1, 1'b1);
      while (mru_ids.size() > CAPACITY / 2)
         send_request(FUNC_REMOVE, mru_ids[$urandom_range(mru_ids.size() - 1)],
                      1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // Stall the response side long enough for the input to back up
   task automatic test_receiver_holdoff();
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = HOLD_OFF;
      repeat (16)
         send_random(50, 25);
      wait_for_replies();
   endtask

   // Random traffic under each idling mix, alternating growth and shrinkage
   task automatic test_random_phases();
      int send_pcts[4];
      int stall_pcts[4];
      send_pcts  = '{0, 64, 0, 32};
      stall_pcts = '{0, 0, 64, 32};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pcts[p];
         rsp_stall_pct = stall_pcts[p];
         for (int n = 0; n < 64; n++) begin
            if ((n / 25) % 2 == 0)
               send_random(65, 20);
            else
               send_random(25, 60);
         end
         wait_for_replies();
      end
   endtask

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_ADD;
      req_bus.ident         = '0;
      req_bus.to_head       = 1'b0;
      req_bus.move_existing = 1'b0;
      foreach (id_pool[i])
         id_pool[i] = $urandom();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_full_list();
      test_receiver_holdoff();
      test_random_phases();

      wait_for_replies();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Stop a hung run
   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
